>>> rtl/core/gvn_pkg.sv
package gvn_pkg;

    localparam int CRD_W  = 32;
    localparam int EW     = CRD_W + 1;
    localparam int PW     = 2 * EW;
    localparam int CW     = PW;
    localparam int MW     = CW - 1;
    localparam int LOW_W  = 33;
    localparam int HIGH_W = MW - LOW_W;
    localparam int SQW    = 2 * MW;
    localparam int SW     = SQW + 2;
    localparam int QW     = 31;
    localparam int NW     = SQW + QW - 1;
    localparam int DW     = SW + QW - 1;
    localparam int RW     = 16;
    localparam int OW     = 16;
    localparam int CFG_W  = 32;
    localparam int MSQ_W  = 2 * CFG_W;
    localparam int CMPW   = SW + 64;

    localparam int IN_DATA_W  = 9 * CRD_W;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 3 * OW;

    localparam logic [CFG_W-1:0] MIN_LEN_RST = 32'd429497;
    localparam logic [OW-1:0]    UNIT_ONE    = 16'd16384;

    typedef logic signed [CRD_W-1:0] t_coord;

    typedef struct packed {
        logic       vld;
        logic       dflt;
        logic [2:0] neg;
    } t_ctl;

endpackage

>>> rtl/core/gvn_cross.sv
module gvn_cross
    import gvn_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  t_coord           i_ctr [3],
    input  t_coord           i_fst [3],
    input  t_coord           i_snd [3],
    input  logic             i_fst_behind,
    input  logic             i_snd_behind,
    input  logic [MSQ_W-1:0] i_min_sq,
    output t_ctl             o_ctl,
    output logic [SQW-1:0]   o_c2 [3],
    output logic [SW-1:0]    o_s
);

    logic [7:0] r_vld;

    logic signed [EW-1:0] r_ea [3];
    logic signed [EW-1:0] r_eb [3];
    logic signed [PW-1:0] r_pr [6];
    logic signed [CW-1:0] r_c  [3];
    logic [MW-1:0]        r_mag [3];
    logic [2:0]           r_neg4, r_neg5, r_neg6, r_neg7, r_neg8;
    logic [2*HIGH_W-1:0]  r_hh [3];
    logic [HIGH_W+LOW_W-1:0] r_hl [3];
    logic [2*LOW_W-1:0]   r_ll [3];
    logic [SQW-1:0]       r_c2_6 [3];
    logic [SQW-1:0]       r_c2_7 [3];
    logic [SQW-1:0]       r_c2_8 [3];
    logic [SW-1:0]        r_s7, r_s8;
    logic                 r_dflt;

    logic signed [EW-1:0] n_ea [3];
    logic signed [EW-1:0] n_eb [3];
    logic                 n_dflt;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_ea[i] = i_fst_behind ?
                ({i_ctr[i][CRD_W-1], i_ctr[i]} - {i_fst[i][CRD_W-1], i_fst[i]}) :
                ({i_fst[i][CRD_W-1], i_fst[i]} - {i_ctr[i][CRD_W-1], i_ctr[i]});
            n_eb[i] = i_snd_behind ?
                ({i_ctr[i][CRD_W-1], i_ctr[i]} - {i_snd[i][CRD_W-1], i_snd[i]}) :
                ({i_snd[i][CRD_W-1], i_snd[i]} - {i_ctr[i][CRD_W-1], i_ctr[i]});
        end
        n_dflt = !({r_s7, 64'b0} > (CMPW'(i_min_sq) << (4 * COORD_FRAC_BITS)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[6:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ea <= n_ea;
            r_eb <= n_eb;

            r_pr[0] <= r_ea[1] * r_eb[2];
            r_pr[1] <= r_ea[2] * r_eb[1];
            r_pr[2] <= r_ea[2] * r_eb[0];
            r_pr[3] <= r_ea[0] * r_eb[2];
            r_pr[4] <= r_ea[0] * r_eb[1];
            r_pr[5] <= r_ea[1] * r_eb[0];

            for (int i = 0; i < 3; i++) begin
                r_c[i]    <= r_pr[2*i] - r_pr[2*i+1];
                r_mag[i]  <= r_c[i][CW-1] ? MW'(-r_c[i]) : MW'(r_c[i]);
                r_neg4[i] <= r_c[i][CW-1];
                r_hh[i]   <= r_mag[i][MW-1:LOW_W] * r_mag[i][MW-1:LOW_W];
                r_hl[i]   <= r_mag[i][MW-1:LOW_W] * r_mag[i][LOW_W-1:0];
                r_ll[i]   <= r_mag[i][LOW_W-1:0] * r_mag[i][LOW_W-1:0];
                r_c2_6[i] <= (SQW'(r_hh[i]) << (2 * LOW_W))
                           + (SQW'(r_hl[i]) << (LOW_W + 1))
                           + SQW'(r_ll[i]);
            end
            r_neg5 <= r_neg4;
            r_neg6 <= r_neg5;
            r_neg7 <= r_neg6;
            r_neg8 <= r_neg7;

            r_s7   <= SW'(r_c2_6[0]) + SW'(r_c2_6[1]) + SW'(r_c2_6[2]);
            r_c2_7 <= r_c2_6;
            r_c2_8 <= r_c2_7;
            r_s8   <= r_s7;
            r_dflt <= n_dflt;
        end
    end

    assign o_ctl = '{vld: r_vld[7], dflt: r_dflt, neg: r_neg8};
    assign o_c2  = r_c2_8;
    assign o_s   = r_s8;

endmodule

>>> rtl/core/gvn_div.sv
module gvn_div
    import gvn_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  t_ctl           i_ctl,
    input  logic [SQW-1:0] i_c2 [3],
    input  logic [SW-1:0]  i_s,
    output t_ctl           o_ctl,
    output logic [QW-1:0]  o_q [3]
);

    localparam int STG = QW;

    t_ctl          r_ctl [STG];
    logic [QW-1:0] r_q   [STG][3];
    logic [NW-1:0] r_rem [STG-1][3];
    logic [SW-1:0] r_d   [STG-1];

    for (genvar k = 0; k < STG; k++) begin : g_stg
        t_ctl          cur_ctl;
        logic [NW-1:0] cur_rem [3];
        logic [QW-1:0] cur_q   [3];
        logic [SW-1:0] cur_d;
        logic [DW-1:0] d_sh;
        logic [NW-1:0] n_rem [3];
        logic [QW-1:0] n_q   [3];

        if (k == 0) begin : g_head
            always_comb begin
                cur_ctl = i_ctl;
                cur_d   = i_s;
                for (int i = 0; i < 3; i++) begin
                    cur_rem[i] = {i_c2[i], {(NW-SQW){1'b0}}};
                    cur_q[i]   = '0;
                end
            end
        end else begin : g_body
            always_comb begin
                cur_ctl = r_ctl[k-1];
                cur_d   = r_d[k-1];
                cur_rem = r_rem[k-1];
                cur_q   = r_q[k-1];
            end
        end

        always_comb begin
            d_sh = DW'(cur_d) << (QW - 1 - k);
            for (int i = 0; i < 3; i++) begin
                if ({{(DW-NW){1'b0}}, cur_rem[i]} >= d_sh) begin
                    n_rem[i] = cur_rem[i] - d_sh[NW-1:0];
                    n_q[i]   = {cur_q[i][QW-2:0], 1'b1};
                end else begin
                    n_rem[i] = cur_rem[i];
                    n_q[i]   = {cur_q[i][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k].vld <= 1'b0;
            end else if (i_en) begin
                r_ctl[k] <= cur_ctl;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k] <= n_q;
            end
        end

        if (k < STG - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_d[k]   <= cur_d;
                end
            end
        end
    end

    assign o_ctl = r_ctl[STG-1];
    assign o_q   = r_q[STG-1];

endmodule

>>> rtl/core/gvn_isqrt.sv
module gvn_isqrt
    import gvn_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  t_ctl          i_ctl,
    input  logic [QW-1:0] i_x [3],
    output t_ctl          o_ctl,
    output logic [RW-1:0] o_root [3]
);

    localparam int STG = RW;

    t_ctl          r_ctl [STG];
    logic [RW-1:0] r_r   [STG][3];
    logic [QW-1:0] r_x   [STG-1][3];

    for (genvar k = 0; k < STG; k++) begin : g_stg
        t_ctl            cur_ctl;
        logic [QW-1:0]   cur_x [3];
        logic [RW-1:0]   cur_r [3];
        logic [RW-1:0]   trial [3];
        logic [2*RW-1:0] sq    [3];
        logic [RW-1:0]   n_r   [3];

        if (k == 0) begin : g_head
            always_comb begin
                cur_ctl = i_ctl;
                cur_x   = i_x;
                for (int i = 0; i < 3; i++) begin
                    cur_r[i] = '0;
                end
            end
        end else begin : g_body
            always_comb begin
                cur_ctl = r_ctl[k-1];
                cur_x   = r_x[k-1];
                cur_r   = r_r[k-1];
            end
        end

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                trial[i] = cur_r[i] | (RW'(1) << (RW - 1 - k));
                sq[i]    = trial[i] * trial[i];
                n_r[i]   = (sq[i] <= (2*RW)'(cur_x[i])) ? trial[i] : cur_r[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k].vld <= 1'b0;
            end else if (i_en) begin
                r_ctl[k] <= cur_ctl;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[k] <= n_r;
            end
        end

        if (k < STG - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[k] <= cur_x;
                end
            end
        end
    end

    assign o_ctl  = r_ctl[STG-1];
    assign o_root = r_r[STG-1];

endmodule

>>> rtl/core/grid_vertex_normal.sv
// Vertex normal of one cloth grid point: edge vectors to the two axis neighbours
// (reversed when a neighbour lies behind), their exact cross product, and the unit
// normal in Q2.14 rounded to nearest, or (0,0,1) with used_default set when the
// cross product length does not exceed min_length. Fully pipelined: one item per
// cycle unless the output is held (8 cross/length stages including the input
// register, 31 divider, 16 square root and 1 output stage). A held output stalls
// the whole pipe; no item is dropped. min_length may be written only while idle.
module grid_vertex_normal
    import gvn_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // center_x, center_y, center_z, first_axis_x/y/z, second_axis_x/y/z
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // first_behind, second_behind
    input  logic [IN_USER_W-1:0]  i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // normal_x, normal_y, normal_z
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // used_default
    output logic [0:0]            o_m_tuser
);

    logic             en;
    logic [CFG_W-1:0] r_min_length;
    logic [MSQ_W-1:0] r_min_sq;

    t_coord ctr [3];
    t_coord fst [3];
    t_coord snd [3];

    t_ctl           x_ctl, d_ctl, q_ctl;
    logic [SQW-1:0] x_c2 [3];
    logic [SW-1:0]  x_s;
    logic [QW-1:0]  d_q [3];
    logic [RW-1:0]  q_root [3];

    logic                  r_out_vld;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_dflt;
    logic [OUT_DATA_W-1:0] n_out_data;
    logic [RW:0]           rnd;
    logic [OW-1:0]         mag;

    assign en         = !r_out_vld || i_m_tready;
    assign o_s_tready = en;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ctr[i] = t_coord'(i_s_tdata[i*CRD_W +: CRD_W]);
            fst[i] = t_coord'(i_s_tdata[(3+i)*CRD_W +: CRD_W]);
            snd[i] = t_coord'(i_s_tdata[(6+i)*CRD_W +: CRD_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= MIN_LEN_RST;
        end else if (i_cfg_we) begin
            r_min_length <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_min_sq <= r_min_length * r_min_length;
    end

    gvn_cross #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_cross (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_vld        (i_s_tvalid),
        .i_ctr        (ctr),
        .i_fst        (fst),
        .i_snd        (snd),
        .i_fst_behind (i_s_tuser[0]),
        .i_snd_behind (i_s_tuser[1]),
        .i_min_sq     (r_min_sq),
        .o_ctl        (x_ctl),
        .o_c2         (x_c2),
        .o_s          (x_s)
    );

    gvn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (x_ctl),
        .i_c2    (x_c2),
        .i_s     (x_s),
        .o_ctl   (d_ctl),
        .o_q     (d_q)
    );

    gvn_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (d_ctl),
        .i_x     (d_q),
        .o_ctl   (q_ctl),
        .o_root  (q_root)
    );

    // rounded component = (isqrt(c^2 * 2^30 / S) + 1) / 2
    always_comb begin
        n_out_data = '0;
        rnd        = '0;
        mag        = '0;
        if (q_ctl.dflt) begin
            n_out_data[2*OW +: OW] = UNIT_ONE;
        end else begin
            for (int i = 0; i < 3; i++) begin
                rnd = {1'b0, q_root[i]} + (RW+1)'(1);
                mag = rnd[OW:1];
                n_out_data[i*OW +: OW] = q_ctl.neg[i] ? (-mag) : mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= q_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= n_out_data;
            r_out_dflt <= q_ctl.dflt;
        end
    end

    assign o_m_tvalid   = r_out_vld;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_dflt;

    a_default_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |->
            o_m_tdata == {UNIT_ONE, {(2*OW){1'b0}}})
        else $error("default item is not (0,0,1)");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            $signed(o_m_tdata[OW-1:0]) >= -16'sd16384 &&
            $signed(o_m_tdata[OW-1:0]) <= 16'sd16384 &&
            $signed(o_m_tdata[2*OW-1:OW]) >= -16'sd16384 &&
            $signed(o_m_tdata[2*OW-1:OW]) <= 16'sd16384 &&
            $signed(o_m_tdata[3*OW-1:2*OW]) >= -16'sd16384 &&
            $signed(o_m_tdata[3*OW-1:2*OW]) <= 16'sd16384)
        else $error("normal component out of range");

    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata != '0)
        else $error("computed normal is zero");

endmodule
